### rtl/rbs_pkg.sv
package rbs_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned CODE_W    = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TAG_W_DEF = 32;

	// opcodes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_SEND = 2'd2;

	// send outcomes
	localparam logic [1:0] OUT_ACCEPTED  = 2'd0;
	localparam logic [1:0] OUT_DISCARD   = 2'd1;
	localparam logic [1:0] OUT_AUTH_ERR  = 2'd2;
	localparam logic [1:0] OUT_RETRYABLE = 2'd3;

	// update codes
	localparam logic [CODE_W-1:0] UPD_NONE      = 3'd0;
	localparam logic [CODE_W-1:0] UPD_IGNORED   = 3'd1;
	localparam logic [CODE_W-1:0] UPD_ACCEPTED  = 3'd2;
	localparam logic [CODE_W-1:0] UPD_DISCARDED = 3'd3;
	localparam logic [CODE_W-1:0] UPD_AUTH_ERR  = 3'd4;
	localparam logic [CODE_W-1:0] UPD_EXHAUSTED = 3'd5;
	localparam logic [CODE_W-1:0] UPD_RETRY     = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXIMUM     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

	localparam logic [DATA_W-1:0]  INITIAL_RESET     = 32'd1000;
	localparam logic [DATA_W-1:0]  MAXIMUM_RESET     = 32'd300000;
	localparam logic [COUNT_W-1:0] RETRY_LIMIT_RESET = 5'd5;

	localparam int unsigned SRV_W = 17;
	localparam int unsigned SRV_MS_W = 27;
	localparam logic [DATA_W-1:0]   MAX_SERVER_DELAY_S = 32'(24 * 60 * 60);
	localparam logic [SRV_MS_W-1:0] MS_PER_S           = 27'd1000;

	// divide by five as multiply by ceil(2^34 / 5), then shift
	localparam int unsigned JITTER_DIVISOR = 5;
	localparam int unsigned RECIP_SHIFT    = 34;
	localparam int unsigned RECIP_W        = 33;
	localparam logic [RECIP_W-1:0] JITTER_RECIP =
		33'(((64'd1 << RECIP_SHIFT) / JITTER_DIVISOR) + 64'd1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_BASE,
		ST_MUL,
		ST_JLIM,
		ST_DSTART,
		ST_DIV,
		ST_SUM,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic base;
		logic mul;
		logic jlim;
		logic dstart;
		logic sum;
		logic fin;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic retry;
		logic jlim_zero;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

### rtl/retry_backoff_scheduler_top.sv
// Retry backoff scheduler: tracks one pending message and its next attempt time.
// Input channel (in_valid / in_stall): one beat per opcode (tick, load, send result)
// with now, msg_tag, outcome, server_delay_s and random_word.
// Output channel (out_valid / out_stall): exactly one result beat per input beat,
// in order: update_code, has_message, attempt_due, retries_done, next_attempt_at.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 initial
// interval, 1 maximum interval, 2 retry limit; cfg_ready is always high. Write only
// while no beat is in flight.
// Sequence: tick, load and non-retry send results go from capture to the evaluate
// state and then the output state. A scheduled retry passes base, multiply, jitter
// limit, divider start, sum and finish states between evaluate and output; a non-zero
// jitter limit adds a serial 32-bit modulo (one bit a cycle, then done) before sum.
// One beat is worked on at a time; in_stall is high from accept until its result
// is moved into the output register. The next beat is taken while that result
// still waits, so a stalled receiver holds back at most the following result.
// Reset clears the pending message and loads the register defaults (1000 ms,
// 300000 ms, 5 retries); out_valid goes low.
module retry_backoff_scheduler_top #(
	parameter int unsigned TAG_WIDTH = rbs_pkg::TAG_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [rbs_pkg::DATA_W-1:0]        now,
	input  logic [rbs_pkg::DATA_W-1:0]        msg_tag,
	input  logic [1:0]                        outcome,
	input  logic [rbs_pkg::DATA_W-1:0]        server_delay_s,
	input  logic [rbs_pkg::DATA_W-1:0]        random_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rbs_pkg::CODE_W-1:0]        update_code,
	output logic                              has_message,
	output logic                              attempt_due,
	output logic [rbs_pkg::COUNT_W-1:0]       retries_done,
	output logic [rbs_pkg::DATA_W-1:0]        next_attempt_at,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbs_pkg::DATA_W-1:0]        cfg_data
);

	rbs_pkg::cmd_t    cmd;
	rbs_pkg::status_t status;

	assign cfg_ready = 1'b1;

	rbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rbs_datapath #(
		.TAG_WIDTH (TAG_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write       (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.now             (now),
		.msg_tag         (msg_tag),
		.outcome         (outcome),
		.server_delay_s  (server_delay_s),
		.random_word     (random_word),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.update_code     (update_code),
		.has_message     (has_message),
		.attempt_due     (attempt_due),
		.retries_done    (retries_done),
		.next_attempt_at (next_attempt_at)
	);

endmodule

### rtl/rbs_divider.sv
module rbs_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rbs_pkg::DATA_W-1:0]    dividend,
	input  logic [rbs_pkg::DATA_W-1:0]    divisor,
	output logic                          done,
	output logic [rbs_pkg::DATA_W-1:0]    remainder
);

	localparam int unsigned W     = rbs_pkg::DATA_W;
	localparam int unsigned CNT_W = $clog2(W);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       shifted;
	logic [W:0]       trial;
	logic             fits;

	// restoring division, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[W-1]};
	assign fits    = shifted >= {1'b0, div_q};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### rtl/rbs_datapath.sv
module rbs_datapath #(
	parameter int unsigned TAG_WIDTH = rbs_pkg::TAG_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rbs_pkg::cmd_t                     cmd,
	output rbs_pkg::status_t                  status,
	input  logic                              cfg_write,
	input  logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbs_pkg::DATA_W-1:0]        cfg_data,
	input  logic [1:0]                        opcode,
	input  logic [rbs_pkg::DATA_W-1:0]        now,
	input  logic [rbs_pkg::DATA_W-1:0]        msg_tag,
	input  logic [1:0]                        outcome,
	input  logic [rbs_pkg::DATA_W-1:0]        server_delay_s,
	input  logic [rbs_pkg::DATA_W-1:0]        random_word,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [rbs_pkg::CODE_W-1:0]        update_code,
	output logic                              has_message,
	output logic                              attempt_due,
	output logic [rbs_pkg::COUNT_W-1:0]       retries_done,
	output logic [rbs_pkg::DATA_W-1:0]        next_attempt_at
);

	localparam int unsigned DW = rbs_pkg::DATA_W;
	localparam int unsigned CW = rbs_pkg::COUNT_W;
	// only the low TAG_WIDTH bits of a tag are kept and compared
	localparam int unsigned SW = (TAG_WIDTH < DW) ? TAG_WIDTH : DW;
	localparam int unsigned PW = DW + rbs_pkg::RECIP_W;

	// configuration
	logic [DW-1:0] initial_q;
	logic [DW-1:0] maximum_q;
	logic [CW-1:0] limit_q;

	// captured item
	logic [1:0]    op_q;
	logic [DW-1:0] now_q;
	logic [SW-1:0] tag_in_q;
	logic [1:0]    outcome_q;
	logic [DW-1:0] delay_q;
	logic [DW-1:0] rnd_q;

	// pending message
	logic          valid_q;
	logic [SW-1:0] tag_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] next_q;

	// working registers
	logic [rbs_pkg::CODE_W-1:0] code_q;
	logic [DW-1:0] base_q;
	logic [DW-1:0] quot5_q;
	logic [DW-1:0] jlim_q;
	logic [DW-1:0] calc_q;
	logic [DW-1:0] srv_q;

	logic                 out_valid_q;
	logic [rbs_pkg::CODE_W-1:0] out_code_q;
	logic                 out_has_q;
	logic                 out_due_q;
	logic [CW-1:0]        out_cnt_q;
	logic [DW-1:0]        out_next_q;

	logic                          match;
	logic [2*DW-1:0]               shifted;
	logic [DW-1:0]                 prod_sat;
	logic [DW-1:0]                 base_next;
	logic [PW-1:0]                 recip_prod;
	logic [DW-1:0]                 room;
	logic [DW-1:0]                 div_rem;
	logic                          div_done;
	logic [DW-1:0]                 jitter;
	logic [rbs_pkg::SRV_W-1:0]     delay_clamp;
	logic [rbs_pkg::SRV_MS_W-1:0]  srv_ms;
	logic [DW-1:0]                 interval;
	logic [DW-1:0]                 since_due;
	logic                          out_take;

	assign match = valid_q && (tag_in_q == tag_q);

	assign status.retry = (op_q == rbs_pkg::OP_SEND) && match
		&& (outcome_q == rbs_pkg::OUT_RETRYABLE) && (cnt_q < limit_q);
	assign status.jlim_zero = (jlim_q == '0);
	assign status.div_done  = div_done;
	assign status.out_free  = !out_valid_q || !out_stall;

	// base interval: initial << retries, saturated, then capped
	assign shifted    = {{DW{1'b0}}, initial_q} << cnt_q;
	assign prod_sat   = (|shifted[2*DW-1:DW]) ? {DW{1'b1}} : shifted[DW-1:0];
	assign base_next  = (prod_sat < maximum_q) ? prod_sat : maximum_q;

	assign recip_prod = {{rbs_pkg::RECIP_W{1'b0}}, base_q}
		* {{DW{1'b0}}, rbs_pkg::JITTER_RECIP};
	assign room       = maximum_q - base_q;
	assign jitter     = status.jlim_zero ? '0 : div_rem;

	assign delay_clamp = (delay_q < rbs_pkg::MAX_SERVER_DELAY_S)
		? delay_q[rbs_pkg::SRV_W-1:0] : rbs_pkg::MAX_SERVER_DELAY_S[rbs_pkg::SRV_W-1:0];
	assign srv_ms   = rbs_pkg::SRV_MS_W'(delay_clamp) * rbs_pkg::MS_PER_S;
	assign interval = (calc_q > srv_q) ? calc_q : srv_q;

	assign since_due = now_q - next_q;
	assign out_take  = out_valid_q && !out_stall;

	rbs_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.dstart && !status.jlim_zero),
		.dividend  (rnd_q),
		.divisor   (jlim_q + 1'b1),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= rbs_pkg::INITIAL_RESET;
			maximum_q <= rbs_pkg::MAXIMUM_RESET;
			limit_q   <= rbs_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rbs_pkg::CFG_INITIAL:     initial_q <= cfg_data;
				rbs_pkg::CFG_MAXIMUM:     maximum_q <= cfg_data;
				rbs_pkg::CFG_RETRY_LIMIT: limit_q   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			now_q     <= now;
			tag_in_q  <= msg_tag[SW-1:0];
			outcome_q <= outcome;
			delay_q   <= server_delay_s;
			rnd_q     <= random_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tag_q   <= '0;
			cnt_q   <= '0;
			next_q  <= '0;
			code_q  <= rbs_pkg::UPD_NONE;
		end else if (cmd.eval) begin
			if (op_q == rbs_pkg::OP_LOAD) begin
				valid_q <= 1'b1;
				tag_q   <= tag_in_q;
				cnt_q   <= '0;
				next_q  <= now_q;
				code_q  <= rbs_pkg::UPD_NONE;
			end else if (op_q == rbs_pkg::OP_SEND) begin
				if (!match) begin
					code_q <= rbs_pkg::UPD_IGNORED;
				end else begin
					unique case (outcome_q)
						rbs_pkg::OUT_ACCEPTED: begin
							valid_q <= 1'b0;
							code_q  <= rbs_pkg::UPD_ACCEPTED;
						end
						rbs_pkg::OUT_DISCARD: begin
							valid_q <= 1'b0;
							code_q  <= rbs_pkg::UPD_DISCARDED;
						end
						rbs_pkg::OUT_AUTH_ERR: begin
							valid_q <= 1'b0;
							code_q  <= rbs_pkg::UPD_AUTH_ERR;
						end
						default: begin
							if (cnt_q >= limit_q) begin
								valid_q <= 1'b0;
								code_q  <= rbs_pkg::UPD_EXHAUSTED;
							end else begin
								code_q <= rbs_pkg::UPD_RETRY;
							end
						end
					endcase
				end
			end else begin
				code_q <= rbs_pkg::UPD_NONE;
			end
		end else if (cmd.base) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.fin) begin
			next_q <= now_q + interval;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.base)
			base_q <= base_next;
		if (cmd.mul)
			quot5_q <= DW'(recip_prod[PW-1:rbs_pkg::RECIP_SHIFT]);
		if (cmd.jlim)
			jlim_q <= (room < quot5_q) ? room : quot5_q;
		if (cmd.sum) begin
			calc_q <= base_q + jitter;
			srv_q  <= DW'(srv_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_take)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_code_q <= code_q;
			out_has_q  <= valid_q;
			out_due_q  <= valid_q && !since_due[DW-1];
			out_cnt_q  <= valid_q ? cnt_q : '0;
			out_next_q <= valid_q ? next_q : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign update_code     = out_code_q;
	assign has_message     = out_has_q;
	assign attempt_due     = out_due_q;
	assign retries_done    = out_cnt_q;
	assign next_attempt_at = out_next_q;

endmodule

### rtl/rbs_ctrl.sv
module rbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rbs_pkg::status_t status,
	output rbs_pkg::cmd_t    cmd
);

	rbs_pkg::state_t state_q;
	rbs_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rbs_pkg::ST_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			rbs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = rbs_pkg::ST_EVAL;
				end
			end
			rbs_pkg::ST_EVAL: begin
				cmd.eval   = 1'b1;
				state_next = status.retry ? rbs_pkg::ST_BASE : rbs_pkg::ST_OUT;
			end
			rbs_pkg::ST_BASE: begin
				cmd.base   = 1'b1;
				state_next = rbs_pkg::ST_MUL;
			end
			rbs_pkg::ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = rbs_pkg::ST_JLIM;
			end
			rbs_pkg::ST_JLIM: begin
				cmd.jlim   = 1'b1;
				state_next = rbs_pkg::ST_DSTART;
			end
			rbs_pkg::ST_DSTART: begin
				// a zero jitter limit skips the modulo
				cmd.dstart = 1'b1;
				state_next = status.jlim_zero ? rbs_pkg::ST_SUM : rbs_pkg::ST_DIV;
			end
			rbs_pkg::ST_DIV: begin
				if (status.div_done)
					state_next = rbs_pkg::ST_SUM;
			end
			rbs_pkg::ST_SUM: begin
				cmd.sum    = 1'b1;
				state_next = rbs_pkg::ST_FIN;
			end
			rbs_pkg::ST_FIN: begin
				cmd.fin    = 1'b1;
				state_next = rbs_pkg::ST_OUT;
			end
			rbs_pkg::ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = rbs_pkg::ST_IDLE;
				end
			end
			default: state_next = rbs_pkg::ST_IDLE;
		endcase
	end

endmodule

### rtl/rbs_checker.sv
module rbs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [rbs_pkg::CODE_W-1:0]        update_code,
	input logic                              has_message,
	input logic                              attempt_due,
	input logic [rbs_pkg::COUNT_W-1:0]       retries_done,
	input logic [rbs_pkg::DATA_W-1:0]        next_attempt_at
);

	// an accepted beat keeps the input side closed in the cycle after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on the cycle after an accept");

	// no pending message means the schedule fields read as zero
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_message |-> !attempt_due && retries_done == '0
			&& next_attempt_at == '0)
		else $error("schedule fields set with no pending message");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> update_code <= rbs_pkg::UPD_RETRY)
		else $error("update code out of range");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(update_code)
			&& $stable(next_attempt_at))
		else $error("stalled result beat changed");

endmodule

bind retry_backoff_scheduler_top rbs_checker u_rbs_checker (.*);
